@@ rtl/bgtr_pkg.sv @@
// Shared types, constants and the palette function of the background tile row renderer.
package bgtr_pkg;

   localparam int VRAM_BYTES  = 8192;
   localparam int VRAM_AW     = 13;
   localparam int MAP_ENTRIES = 1024;
   localparam int ENTRY_W     = 10;
   localparam int CSR_AW      = 2;
   localparam int CSR_DW      = 8;

   localparam logic [VRAM_AW-1:0] MAP0_OFS = 13'h1800;
   localparam logic [VRAM_AW-1:0] MAP1_OFS = 13'h1C00;
   localparam logic [8:0]         SIGNED_BASE_TILE = 9'h100;
   localparam logic [VRAM_AW-1:0] CLEAR_LAST = 13'h1FFF;

   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_RENDER = 1'b1;

   typedef enum logic [1:0] {
      CSR_DISPLAY_ENABLE   = 2'd0,
      CSR_TILE_DATA_SELECT = 2'd1,
      CSR_MAP_SELECT       = 2'd2,
      CSR_BG_PALETTE       = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MAP,
      ST_LO,
      ST_HI
   } state_type;

   typedef struct packed {
      logic               we;
      logic               re;
      logic [VRAM_AW-1:0] addr;
      logic [7:0]         wdata;
   } mem_req_type;

   function automatic logic [15:0] shade_row(input logic [7:0] lo, input logic [7:0] hi,
                                             input logic [7:0] pal);
      logic [15:0] shades;
      logic [1:0]  c;
      shades = '0;
      for (int k = 0; k < 8; k++) begin
         c = {hi[7-k], lo[7-k]};
         shades[15-2*k -: 2] = pal[2*c +: 2];
      end
      return shades;
   endfunction

endpackage

@@ rtl/bgtr_if.sv @@
// Valid/ready channel interfaces for request and result items.
interface bgtr_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [12:0] vram_offset;
   logic [7:0]  write_byte;
   logic [9:0]  map_entry;
   logic [2:0]  tile_row;

   modport source (output valid, func, vram_offset, write_byte, map_entry, tile_row,
                   input ready);
   modport sink (input valid, func, vram_offset, write_byte, map_entry, tile_row,
                 output ready);
endinterface

interface bgtr_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  buffer_x;
   logic [7:0]  buffer_y;
   logic [15:0] row_shades;

   modport source (output valid, buffer_x, buffer_y, row_shades, input ready);
   modport sink (input valid, buffer_x, buffer_y, row_shades, output ready);
endinterface

@@ rtl/bgtr_vram.sv @@
// Single-port video memory with registered read data.
module bgtr_vram (
   input  logic                   clock,
   input  bgtr_pkg::mem_req_type  mem_req,
   output logic [7:0]             rdata
);
   import bgtr_pkg::*;

   logic [7:0] mem [VRAM_BYTES];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.addr] <= mem_req.wdata;
      end
      if (mem_req.re) begin
         rdata_ff <= mem[mem_req.addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/bgtr_ctrl.sv @@
// Sequencer for memory clearing, byte writes and tile row fetches, with the result register.
module bgtr_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   bgtr_req_if.sink                      req,
   bgtr_rsp_if.source                    rsp,
   input  logic                          csr_we,
   input  logic [bgtr_pkg::CSR_AW-1:0]   csr_index,
   input  logic [bgtr_pkg::CSR_DW-1:0]   csr_wdata,
   output bgtr_pkg::mem_req_type         mem_req,
   input  logic [7:0]                    mem_rdata
);
   import bgtr_pkg::*;

   state_type          state_ff, state_in;
   logic [VRAM_AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [ENTRY_W-1:0] entry_ff, entry_in;
   logic [2:0]         row_ff, row_in;
   logic [8:0]         tile_ff, tile_in;
   logic [7:0]         lo_ff, lo_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         buffer_x_ff, buffer_x_in;
   logic [7:0]         buffer_y_ff, buffer_y_in;
   logic [15:0]        shades_ff, shades_in;
   logic               display_enable_ff, tile_data_select_ff, map_select_ff;
   logic [7:0]         bg_palette_ff;
   logic               accept;
   logic               render_go;
   logic               rsp_free;
   logic [8:0]         tile_idx;

   assign accept    = req.valid && req.ready;
   assign render_go = accept && (req.func == FUNC_RENDER) && display_enable_ff;
   assign rsp_free  = !rsp_valid_ff || rsp.ready;
   assign tile_idx  = tile_data_select_ff ? {1'b0, mem_rdata}
                                          : SIGNED_BASE_TILE + {mem_rdata[7], mem_rdata};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == CLEAR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (render_go) begin
               state_in = ST_MAP;
            end
         end
         ST_MAP: state_in = ST_LO;
         ST_LO:  state_in = ST_HI;
         ST_HI: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      req.ready     = 1'b0;
      mem_req       = '0;
      clr_cnt_in    = clr_cnt_ff;
      entry_in      = entry_ff;
      row_in        = row_ff;
      tile_in       = tile_ff;
      lo_in         = lo_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      buffer_x_in   = buffer_x_ff;
      buffer_y_in   = buffer_y_ff;
      shades_in     = shades_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_req.we   = 1'b1;
            mem_req.addr = clr_cnt_ff;
            clr_cnt_in   = clr_cnt_ff + 1'b1;
         end
         ST_IDLE: begin
            req.ready = 1'b1;
            entry_in  = req.map_entry;
            row_in    = req.tile_row;
            if (accept && (req.func == FUNC_WRITE)) begin
               mem_req.we    = 1'b1;
               mem_req.addr  = req.vram_offset;
               mem_req.wdata = req.write_byte;
            end else if (render_go) begin
               mem_req.re   = 1'b1;
               mem_req.addr = (map_select_ff ? MAP1_OFS : MAP0_OFS)
                              + {{(VRAM_AW-ENTRY_W){1'b0}}, req.map_entry};
            end
         end
         ST_MAP: begin
            tile_in      = tile_idx;
            mem_req.re   = 1'b1;
            mem_req.addr = {tile_idx, row_ff, 1'b0};
         end
         ST_LO: begin
            lo_in        = mem_rdata;
            mem_req.re   = 1'b1;
            mem_req.addr = {tile_ff, row_ff, 1'b1};
         end
         ST_HI: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               buffer_x_in  = {entry_ff[4:0], 3'b000};
               buffer_y_in  = {entry_ff[9:5], row_ff};
               shades_in    = shade_row(lo_ff, mem_rdata, bg_palette_ff);
            end
         end
         default: begin
            clr_cnt_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= ST_CLEAR;
         clr_cnt_ff          <= '0;
         rsp_valid_ff        <= 1'b0;
         display_enable_ff   <= 1'b0;
         tile_data_select_ff <= 1'b0;
         map_select_ff       <= 1'b0;
         bg_palette_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_DISPLAY_ENABLE:   display_enable_ff   <= csr_wdata[0];
               CSR_TILE_DATA_SELECT: tile_data_select_ff <= csr_wdata[0];
               CSR_MAP_SELECT:       map_select_ff       <= csr_wdata[0];
               CSR_BG_PALETTE:       bg_palette_ff       <= csr_wdata;
               default:              bg_palette_ff       <= bg_palette_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff    <= entry_in;
      row_ff      <= row_in;
      tile_ff     <= tile_in;
      lo_ff       <= lo_in;
      buffer_x_ff <= buffer_x_in;
      buffer_y_ff <= buffer_y_in;
      shades_ff   <= shades_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.buffer_x   = buffer_x_ff;
   assign rsp.buffer_y   = buffer_y_ff;
   assign rsp.row_shades = shades_ff;

endmodule

@@ rtl/background_tile_row_renderer_top.sv @@
// Top level of the background tile row renderer.
//
// Each request item either writes one byte of the 8 KiB video memory (func 0) or renders
// one 8-pixel row of a background map entry (func 1). A render reads the tile number from
// the selected map, then the low and high plane bytes, and returns one result item with
// the palette shades and the buffer coordinates. Writes and renders while the display is
// disabled give no result. Configuration registers are written through the csr_ port.
// A write item is written to the video memory in the cycle it is accepted. A render item
// passes through the map, low and high read states, one per read of the single-port video
// memory, before its result is registered; the next item is accepted only after that. The
// result sits in an output register, so a new item is accepted while an earlier result
// waits; a render that finishes while that register is still full waits until it is
// taken, and no further item is accepted in that time.
// After reset the block clears all 8192 bytes of the video memory, one byte per cycle, with
// req_chan.ready low; configuration writes are taken during that time.
module background_tile_row_renderer_top (
   input  logic                          clock,
   input  logic                          reset,
   bgtr_req_if.sink                      req_chan,
   bgtr_rsp_if.source                    rsp_chan,
   input  logic                          csr_we,
   input  logic [bgtr_pkg::CSR_AW-1:0]   csr_index,
   input  logic [bgtr_pkg::CSR_DW-1:0]   csr_wdata
);
   import bgtr_pkg::*;

   mem_req_type mem_req;
   logic [7:0]  mem_rdata;

   bgtr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .rsp       (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

   bgtr_vram u_vram (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (mem_rdata)
   );

endmodule

@@ rtl/bgtr_checker.sv @@
// Port-level assertions for the background tile row renderer and their bind.
module bgtr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_func,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  buffer_x,
   input logic [7:0]  buffer_y,
   input logic [15:0] row_shades
);
   import bgtr_pkg::*;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("Result item dropped while stalled.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(buffer_x) && $stable(buffer_y) && $stable(row_shades))
      else $error("Result item changed while stalled.");

   assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("Block is not held off after reset.");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_func == FUNC_WRITE) && !rsp_valid |=> !rsp_valid)
      else $error("A write item produced a result.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> buffer_x[2:0] == 3'b000)
      else $error("Result column is not tile aligned.");

endmodule

bind background_tile_row_renderer_top bgtr_checker u_bgtr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .req_func   (req_chan.func),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .buffer_x   (rsp_chan.buffer_x),
   .buffer_y   (rsp_chan.buffer_y),
   .row_shades (rsp_chan.row_shades)
);
